>>> sv/ordered_pair_list_core_macros.svh
// Assertion macros shared by the ordered pair list RTL.
`ifndef ORDERED_PAIR_LIST_CORE_MACROS_SVH
`define ORDERED_PAIR_LIST_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on i_clk, ignored while i_rst_n is low.
`define OPL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on i_clk, also during reset.
`define OPL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define OPL_ASSERT(lbl, prop, msg)
`define OPL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> sv/opl_pkg.sv
// Types and constants of the ordered pair list.
package opl_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int COORD_W = 16;

    typedef enum logic [1:0] {
        ACT_FRONT  = 2'd0,
        ACT_BACK   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] pair_x;
        logic signed [COORD_W-1:0] pair_y;
        logic [POS_W-1:0]          position;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] length;
    } t_rsp;

    // Slot update command from the control to the slot array
    typedef struct packed {
        logic             push_front;
        logic             push_back;
        logic             remove;
        logic [IDX_W-1:0] idx;
    } t_slot_ctl;

endpackage

>>> sv/opl_slots.sv
// Slot array: per-slot muxes shift the pairs or write the request pair into one slot.
module opl_slots (
    input  logic                                i_clk,
    input  opl_pkg::t_slot_ctl                  i_ctl,
    input  logic signed [opl_pkg::COORD_W-1:0]  i_pair_x,
    input  logic signed [opl_pkg::COORD_W-1:0]  i_pair_y
);

    logic signed [opl_pkg::COORD_W-1:0] r_slot_x [opl_pkg::DEPTH];
    logic signed [opl_pkg::COORD_W-1:0] r_slot_y [opl_pkg::DEPTH];
    logic signed [opl_pkg::COORD_W-1:0] n_slot_x [opl_pkg::DEPTH];
    logic signed [opl_pkg::COORD_W-1:0] n_slot_y [opl_pkg::DEPTH];

    // Select each slot's next pair from itself, a neighbor or the request
    always_comb begin
        for (int i = 0; i < opl_pkg::DEPTH; i++) begin
            n_slot_x[i] = r_slot_x[i];
            n_slot_y[i] = r_slot_y[i];
            if (i_ctl.push_front) begin
                if (i == 0) begin
                    n_slot_x[i] = i_pair_x;
                    n_slot_y[i] = i_pair_y;
                end else begin
                    n_slot_x[i] = r_slot_x[(i == 0) ? 0 : i - 1];
                    n_slot_y[i] = r_slot_y[(i == 0) ? 0 : i - 1];
                end
            end else if (i_ctl.push_back) begin
                if (opl_pkg::IDX_W'(i) == i_ctl.idx) begin
                    n_slot_x[i] = i_pair_x;
                    n_slot_y[i] = i_pair_y;
                end
            end else if (i_ctl.remove) begin
                if (i < opl_pkg::DEPTH - 1 && opl_pkg::IDX_W'(i) >= i_ctl.idx) begin
                    n_slot_x[i] = r_slot_x[(i < opl_pkg::DEPTH - 1) ? i + 1 : i];
                    n_slot_y[i] = r_slot_y[(i < opl_pkg::DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // Hold the pairs
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < opl_pkg::DEPTH; i++) begin
            r_slot_x[i] <= n_slot_x[i];
            r_slot_y[i] <= n_slot_y[i];
        end
    end

endmodule

>>> sv/opl_ctrl.sv
// Entry count, request decode and status for the ordered pair list.
`include "ordered_pair_list_core_macros.svh"

module opl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  opl_pkg::t_req      i_req,
    output opl_pkg::t_rsp      o_rsp,
    output opl_pkg::t_slot_ctl o_slot_ctl
);

    logic [opl_pkg::CNT_W-1:0] r_count;
    logic [opl_pkg::CNT_W-1:0] n_count;
    logic                      full;
    logic                      bad_pos;
    logic [opl_pkg::POS_W-1:0] pos_m1;

    // Classify the request against the current count
    always_comb begin
        full    = (r_count == opl_pkg::CNT_W'(opl_pkg::DEPTH));
        bad_pos = (i_req.position == '0) ||
                  ({{opl_pkg::CNT_W{1'b0}}, i_req.position} >
                   {{opl_pkg::POS_W{1'b0}}, r_count});
        pos_m1  = i_req.position - opl_pkg::POS_W'(1);
    end

    // Decide status, next count and the slot command
    always_comb begin
        o_rsp.status = opl_pkg::ST_DONE;
        n_count      = r_count;
        o_slot_ctl   = '0;
        case (i_req.action)
            opl_pkg::ACT_FRONT: begin
                if (full) begin
                    o_rsp.status = opl_pkg::ST_FULL;
                end else begin
                    n_count               = r_count + opl_pkg::CNT_W'(1);
                    o_slot_ctl.push_front = i_fire;
                end
            end
            opl_pkg::ACT_BACK: begin
                if (full) begin
                    o_rsp.status = opl_pkg::ST_FULL;
                end else begin
                    n_count              = r_count + opl_pkg::CNT_W'(1);
                    o_slot_ctl.push_back = i_fire;
                    o_slot_ctl.idx       = opl_pkg::IDX_W'(r_count);
                end
            end
            opl_pkg::ACT_REMOVE: begin
                if (bad_pos) begin
                    o_rsp.status = opl_pkg::ST_BADPOS;
                end else begin
                    n_count           = r_count - opl_pkg::CNT_W'(1);
                    o_slot_ctl.remove = i_fire;
                    o_slot_ctl.idx    = opl_pkg::IDX_W'(pos_m1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        o_rsp.length = n_count;
    end

    // Advance the count on each processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    `OPL_ASSERT(a_count_bound, r_count <= opl_pkg::CNT_W'(opl_pkg::DEPTH), "count above depth")
    `OPL_ASSERT(a_refused_hold, i_fire && o_rsp.status != opl_pkg::ST_DONE |=> $stable(r_count), "refused request changed count")
    `OPL_ASSERT(a_remove_dec, i_fire && o_slot_ctl.remove |=> r_count + opl_pkg::CNT_W'(1) == $past(r_count), "remove did not decrement")

endmodule

>>> sv/ordered_pair_list_core.sv
// Top level of the ordered pair list: request register, control, slots, result register.
//
// Usage:
//   Requests arrive on i_in_valid / o_in_ready with payload i_in_req
//   (action, pair_x, pair_y, position). Each request yields exactly one
//   response on o_out_valid / i_out_ready with payload o_out_rsp
//   (status, length).
//   A request register feeds the decode and slot update logic, which
//   loads the response register.
//   Throughput: one request per cycle while the receiver takes responses.
//   The slot array updates through per-slot muxes, so no operation iterates.
//   Reset (i_rst_n low, synchronous) empties the list and drops any
//   request or response in flight; slot contents are not cleared.
//   When the receiver stalls, the response holds, the request register
//   fills, and then o_in_ready drops until the response is taken.
`include "ordered_pair_list_core_macros.svh"

module ordered_pair_list_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  opl_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output opl_pkg::t_rsp o_out_rsp
);

    logic               r_in_valid;
    opl_pkg::t_req      r_in_req;
    logic               r_out_valid;
    opl_pkg::t_rsp      r_out_rsp;
    logic               advance;
    opl_pkg::t_rsp      rsp;
    opl_pkg::t_slot_ctl slot_ctl;

    // Move the held request on when the response register is empty or its response is taken
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Hold the incoming request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_req <= i_in_req;
        end
    end

    opl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_req      (r_in_req),
        .o_rsp      (rsp),
        .o_slot_ctl (slot_ctl)
    );

    opl_slots u_slots (
        .i_clk    (i_clk),
        .i_ctl    (slot_ctl),
        .i_pair_x (r_in_req.pair_x),
        .i_pair_y (r_in_req.pair_y)
    );

    // Load the response, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rsp <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    `OPL_ASSERT(a_in_hold, r_in_valid && !advance |=> r_in_valid, "held request lost")
    `OPL_ASSERT(a_advance_out, advance |=> r_out_valid, "processed request gave no response")
    `OPL_ASSERT_ALWAYS(a_empty_ready, !r_in_valid |-> o_in_ready, "empty request register not ready")

endmodule

>>> sim/ordered_pair_list_core_test.sv
// Self-checking testbench for the ordered pair list core.
module ordered_pair_list_core_test;

    import opl_pkg::*;

    localparam int IDLE_PCT     = 15;
    localparam int STALL_CYCLES = 120;
    localparam int WATCHDOG_MAX = 2000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pair;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_req in_req    = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_rsp out_rsp;

    // Shadow list contents and responses still owed by the core
    t_pair       pair_list[$];
    t_rsp        expected_rsps[$];
    int unsigned mismatch_count;
    int unsigned watchdog_count;
    int unsigned stall_left;
    bit          stall_trigger;
    bit          no_idle;

    ordered_pair_list_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one request to the shadow list and return the response it owes
    function automatic t_rsp apply_list_op(input t_req req);
        t_rsp  rsp;
        t_pair entry;
        rsp.status = ST_DONE;
        entry.x = req.pair_x;
        entry.y = req.pair_y;
        case (t_action'(req.action))
            ACT_FRONT: begin
                if (pair_list.size() >= DEPTH) rsp.status = ST_FULL;
                else pair_list.push_front(entry);
            end
            ACT_BACK: begin
                if (pair_list.size() >= DEPTH) rsp.status = ST_FULL;
                else pair_list.push_back(entry);
            end
            ACT_REMOVE: begin
                if (req.position == 0 || req.position > pair_list.size()) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    pair_list.delete(req.position - 1);
                end
            end
            default: begin
            end
        endcase
        rsp.length = CNT_W'(pair_list.size());
        return rsp;
    endfunction

    function automatic t_req make_request(input t_action act, input int x, input int y,
                                          input int pos);
        t_req req;
        req.action   = act;
        req.pair_x   = COORD_W'(x);
        req.pair_y   = COORD_W'(y);
        req.position = POS_W'(pos);
        return req;
    endfunction

    // Draw a request; grow_pct biases toward inserts, removes mostly hit live entries
    function automatic t_req random_request(input int unsigned grow_pct);
        t_req req;
        req.pair_x   = COORD_W'($urandom);
        req.pair_y   = COORD_W'($urandom);
        req.position = POS_W'($urandom);
        if ($urandom_range(99) < 5) begin
            req.action = ACT_NONE;
        end else if ($urandom_range(99) < grow_pct) begin
            req.action = $urandom_range(1) ? ACT_BACK : ACT_FRONT;
        end else begin
            req.action = ACT_REMOVE;
            if (pair_list.size() != 0 && $urandom_range(99) < 80)
                req.position = POS_W'($urandom_range(pair_list.size(), 1));
        end
        return req;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Offer one request, hold it until accepted, then record its response
    task automatic send_request(input t_req req);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (!in_ready);
        expected_rsps.push_back(apply_list_op(req));
    endtask

    // Drop valid and wait until every owed response has come back
    task automatic drain_responses();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_rsps.size() != 0);
    endtask

    task automatic run_random(input int count, input int unsigned grow_pct);
        repeat (count) send_request(random_request(grow_pct));
    endtask

    task automatic test_directed_cases();
        send_request(make_request(ACT_REMOVE, 0, 0, 1));            // remove from empty list
        send_request(make_request(ACT_REMOVE, 0, 0, 0));            // position zero
        send_request(make_request(ACT_NONE, 32'h5a5a, 32'ha5a5, 31));
        send_request(make_request(ACT_FRONT, -32768, 32767, 0));
        send_request(make_request(ACT_BACK, 32767, -32768, 31));
        send_request(make_request(ACT_FRONT, 0, -1, 16));
        send_request(make_request(ACT_BACK, -1, 0, 1));
        send_request(make_request(ACT_REMOVE, -1, -1, 0));
        send_request(make_request(ACT_REMOVE, 0, 0, 31));
        send_request(make_request(ACT_REMOVE, 0, 0, 5));            // one past the end
        send_request(make_request(ACT_REMOVE, 0, 0, 4));            // last entry
        send_request(make_request(ACT_REMOVE, 0, 0, 2));            // middle entry
        send_request(make_request(ACT_REMOVE, 0, 0, 1));            // front entry
        send_request(make_request(ACT_NONE, -1, -1, 0));
        send_request(make_request(ACT_REMOVE, 0, 0, 1));            // only entry
        send_request(make_request(ACT_REMOVE, 0, 0, 16));
    endtask

    // Grow past full so both inserts are refused, then shrink past empty
    task automatic test_fill_and_empty();
        run_random(150, 90);
        run_random(150, 10);
        run_random(100, 90);
        run_random(100, 10);
    endtask

    task automatic test_mixed_random();
        run_random(350, 55);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_random(200, 60);
        no_idle = 1'b0;
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_output_stall();
        stall_trigger = 1'b1;
        run_random(60, 50);
    endtask

    task automatic test_sender_pause();
        run_random(80, 50);
        drain_responses();
        run_random(80, 50);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (stall_trigger) begin
            stall_trigger = 1'b0;
            stall_left    = STALL_CYCLES;
        end
        if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each accepted response with the oldest owed one
    always @(posedge clk) begin : check_response
        t_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected response length", out_rsp.length, -1);
            end else begin
                want = expected_rsps.pop_front();
                if (out_rsp.status !== want.status)
                    report_mismatch("status", out_rsp.status, want.status);
                if (out_rsp.length !== want.length)
                    report_mismatch("length", out_rsp.length, want.length);
            end
        end
    end

    // Abort when no request or response moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            watchdog_count <= 0;
        end else if (watchdog_count >= WATCHDOG_MAX) begin
            $display("ordered_pair_list_core verification failed");
            $finish;
        end else begin
            watchdog_count <= watchdog_count + 1;
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_fill_and_empty();
        test_mixed_random();
        test_back_to_back();
        test_output_stall();
        test_sender_pause();
        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0) begin
            $display("ordered_pair_list_core verification clean");
        end else begin
            $display("ordered_pair_list_core verification failed");
        end
        $finish;
    end

endmodule
